[src/sprc_pkg.sv]
// Shared types, codes and the frame size table for the sprite rescale throttle.
// No dependencies; every other file of the block imports this package.
package sprc_pkg;

  localparam int FRAME_COUNT    = 16;
  localparam int FRAME_MAX_SIZE = 64;
  localparam logic [7:0] SKIP_SAT = 8'hFF;

  // Sprite sizes for each frame, ascending.
  localparam logic [7:0] FRAME_SIZES [FRAME_COUNT] = '{
    8'd8,  8'd11, 8'd15, 8'd18, 8'd22, 8'd25, 8'd29, 8'd32,
    8'd36, 8'd39, 8'd43, 8'd46, 8'd50, 8'd53, 8'd57, 8'd60
  };

  typedef enum logic [1:0] {
    CMD_BEGIN_FRAME = 2'd0,
    CMD_PLACE       = 2'd1,
    CMD_CLEAR_SLOT  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MIN_SIZE       = 2'd0,
    REG_FAR_CULL_DEPTH = 2'd1,
    REG_RESCALE_BUDGET = 2'd2,
    REG_MAX_SKIP       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  min_size;
    logic [15:0] far_cull_depth;
    logic [7:0]  rescale_budget;
    logic [7:0]  max_skip;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  slot;
    logic [15:0] caster_size;
    logic [15:0] depth_z;
  } item_t;

  typedef struct packed {
    logic       visible;
    logic [3:0] frame;
    logic       frame_updated;
    logic       change_skipped;
  } res_t;

  // Nearest table entry, ties to the lower index. The table is sorted, so the
  // answer is the last midpoint that twice the size lies strictly above.
  function automatic logic [3:0] frame_pick(input logic [15:0] size);
    logic [3:0] idx;
    logic [7:0] mid2;
    idx = '0;
    if (size > 16'(FRAME_MAX_SIZE)) begin
      idx = 4'(FRAME_COUNT - 1);
    end else begin
      for (int i = 0; i < FRAME_COUNT - 1; i++) begin
        mid2 = FRAME_SIZES[i] + FRAME_SIZES[i+1];
        if ({size[6:0], 1'b0} > mid2) begin
          idx = 4'(i + 1);
        end
      end
    end
    return idx;
  endfunction

endpackage

[src/sprc_cfg_regs.sv]
// Configuration register file of the sprite rescale throttle.
// Depends on sprc_pkg for the register codes and the cfg_t bundle.
module sprc_cfg_regs
  import sprc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_MIN_SIZE:       cfg_nxt.min_size       = wr_data[7:0];
        REG_FAR_CULL_DEPTH: cfg_nxt.far_cull_depth = wr_data;
        REG_RESCALE_BUDGET: cfg_nxt.rescale_budget = wr_data[7:0];
        REG_MAX_SKIP:       cfg_nxt.max_skip       = wr_data[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_size       <= 8'd4;
      cfg_r.far_cull_depth <= 16'hFFFF;
      cfg_r.rescale_budget <= 8'd2;
      cfg_r.max_skip       <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/sprc_core.sv]
// Per-slot frame state, credit counter and the combinational command decision.
// Depends on sprc_pkg for item_t, res_t, cfg_t, codes and frame_pick.
module sprc_core
  import sprc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [3:0] frame_r [SLOTS];
  logic [7:0] skips_r [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [7:0] credits_r;
  logic [7:0] credits_nxt;

  logic [SLOT_W-1:0] idx;
  logic       hit;
  logic       cur_valid;
  logic [3:0] cur_frame;
  logic [7:0] cur_skips;
  logic       is_place;
  logic       is_clear;
  logic       culled;
  logic       shown;
  logic [3:0] want;
  logic       differs;
  logic       allow;
  logic       apply;
  logic       refuse;

  assign idx       = SLOT_W'(item.slot);
  assign hit       = {4'b0, item.slot} < 9'(SLOTS);
  assign cur_valid = valid_r[idx];
  assign cur_frame = frame_r[idx];
  assign cur_skips = skips_r[idx];

  assign is_place = (cmd_t'(item.command) == CMD_PLACE) && hit;
  assign is_clear = (cmd_t'(item.command) == CMD_CLEAR_SLOT) && hit;
  assign culled   = (item.caster_size < {8'b0, cfg.min_size}) ||
                    (item.depth_z >= cfg.far_cull_depth);
  assign shown    = is_place && !culled;

  assign want    = frame_pick(item.caster_size);
  assign differs = !cur_valid || (want != cur_frame);
  assign allow   = !cur_valid || (credits_r != 8'd0) || (cur_skips >= cfg.max_skip);
  assign apply   = shown && differs && allow;
  assign refuse  = shown && differs && !allow;

  always_comb begin
    credits_nxt = credits_r;
    if (cmd_t'(item.command) == CMD_BEGIN_FRAME) begin
      credits_nxt = cfg.rescale_budget;
    end else if (apply && cur_valid && (credits_r != 8'd0)) begin
      credits_nxt = credits_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credits_r <= '0;
      valid_r   <= '0;
    end else if (fire) begin
      credits_r <= credits_nxt;
      if (is_clear) begin
        valid_r[idx] <= 1'b0;
      end else if (apply) begin
        valid_r[idx] <= 1'b1;
      end
    end
  end

  // frame and skip count only matter while the slot is valid: no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      if (is_clear) begin
        skips_r[idx] <= '0;
      end else if (apply) begin
        frame_r[idx] <= want;
        skips_r[idx] <= '0;
      end else if (refuse) begin
        if (cur_skips != SKIP_SAT) begin
          skips_r[idx] <= cur_skips + 8'd1;
        end
      end else if (shown) begin
        skips_r[idx] <= '0;
      end
    end
  end

  always_comb begin
    res                = '0;
    res.visible        = shown;
    res.frame          = shown ? (apply ? want : cur_frame) : 4'd0;
    res.frame_updated  = apply;
    res.change_skipped = refuse;
  end

endmodule

[src/sprite_rescale_credit_throttle.sv]
// Sprite shadow frame selector with a per-display-frame rescale credit budget.
// Requests are held in the input register, results in the result register.
// Throughput: one request per cycle while the result channel is not stalled; the
// state update is combinational logic between the input and result registers.
// Reset (rst_n low, synchronous): all slots invalid, credits zero, registers
// back to min_size 4, far_cull_depth 65535, rescale_budget 2, max_skip 3.
module sprite_rescale_credit_throttle
  import sprc_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_slot,
  input  logic [15:0] in_caster_size,
  input  logic [15:0] in_depth_z,

  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_visible,
  output logic [3:0]  out_frame,
  output logic        out_frame_updated,
  output logic        out_change_skipped,

  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  res_t  res;

  // Input register holds one request; it is consumed when the result
  // register is empty or being drained this cycle.
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  item_t s1_item_r;

  logic  out_valid_r;
  logic  out_valid_nxt;
  res_t  out_res_r;

  logic  in_take;
  logic  out_free;
  logic  fire;

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.command     <= in_command;
      s1_item_r.slot        <= in_slot;
      s1_item_r.caster_size <= in_caster_size;
      s1_item_r.depth_z     <= in_depth_z;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  sprc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Slot state is read and written in the cycle a request leaves the input
  // register, so back-to-back requests to one slot see each other's updates.
  sprc_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_valid          = out_valid_r;
  assign out_visible        = out_res_r.visible;
  assign out_frame          = out_res_r.frame;
  assign out_frame_updated  = out_res_r.frame_updated;
  assign out_change_skipped = out_res_r.change_skipped;

endmodule

[tb/sv/tb_sprite_rescale_credit_throttle.sv]
// Self-checking testbench for sprite_rescale_credit_throttle: directed and random
// requests, register settings and stall patterns, checked against a frame/credit model.
// Depends on sprc_pkg and the block's RTL only.
module tb_sprite_rescale_credit_throttle
  import sprc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS     = 32;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_WAIT  = 8;          // idle watch after the final drain

  // Command code 3 is not decoded by the block; it must be a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Frame and credit model. Holds its own copy of the slot state and the
  // registers; each accepted request pushes its predicted result, each
  // accepted result is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  class shadow_frame_model;
    cfg_t       regs;
    logic [3:0] frame_held  [N_SLOTS];
    logic       frame_known [N_SLOTS];
    logic [7:0] skip_count  [N_SLOTS];
    logic [7:0] credits;
    res_t       predicted_q [$];
    int         errors, requests, shown, changes, refusals, culled;

    function new();
      regs = '{min_size: 8'd4, far_cull_depth: 16'hFFFF,
               rescale_budget: 8'd2, max_skip: 8'd3};
      foreach (frame_held[i]) begin
        frame_held[i]  = '0;
        frame_known[i] = 1'b0;
        skip_count[i]  = '0;
      end
      credits  = '0;
      errors   = 0;
      requests = 0;
      shown    = 0;
      changes  = 0;
      refusals = 0;
      culled   = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] data);
      case (idx)
        REG_MIN_SIZE:       regs.min_size       = data[7:0];
        REG_FAR_CULL_DEPTH: regs.far_cull_depth = data;
        REG_RESCALE_BUDGET: regs.rescale_budget = data[7:0];
        REG_MAX_SKIP:       regs.max_skip       = data[7:0];
        default: ;
      endcase
    endfunction

    // Closest table entry by absolute distance; strict compare keeps the
    // lower index on a tie. Anything past the largest size gets the top frame.
    function logic [3:0] nearest_frame(logic [15:0] size);
      int         gap;
      int         best_dist;
      logic [3:0] best;
      best      = '0;
      best_dist = 1 << 30;
      if (size > 16'(FRAME_MAX_SIZE)) return 4'(FRAME_COUNT - 1);
      for (int i = 0; i < FRAME_COUNT; i++) begin
        gap = int'(size) - int'(FRAME_SIZES[i]);
        if (gap < 0) gap = -gap;
        if (gap < best_dist) begin
          best_dist = gap;
          best      = 4'(i);
        end
      end
      return best;
    endfunction

    function void note_request(item_t req);
      res_t       r;
      logic [3:0] want;
      logic [4:0] s;
      logic       was_known;
      r = '0;
      s = req.slot;
      requests++;
      case (req.command)
        CMD_BEGIN_FRAME: credits = regs.rescale_budget;
        CMD_CLEAR_SLOT: begin
          frame_known[s] = 1'b0;
          skip_count[s]  = '0;
        end
        CMD_PLACE: begin
          if (req.caster_size < 16'(regs.min_size) ||
              req.depth_z >= regs.far_cull_depth) begin
            culled++;                      // hidden, state untouched
          end else begin
            want      = nearest_frame(req.caster_size);
            was_known = frame_known[s];
            if (!was_known || want != frame_held[s]) begin
              if (!was_known || credits != 0 || skip_count[s] >= regs.max_skip) begin
                frame_held[s]  = want;
                frame_known[s] = 1'b1;
                skip_count[s]  = '0;
                // first placement of a slot is free
                if (was_known && credits != 0) credits = credits - 8'd1;
                r.frame_updated = 1'b1;
                changes++;
              end else begin
                if (skip_count[s] != SKIP_SAT) skip_count[s] = skip_count[s] + 8'd1;
                r.change_skipped = 1'b1;
                refusals++;
              end
            end else begin
              skip_count[s] = '0;
            end
            r.visible = 1'b1;
            r.frame   = frame_held[s];
            shown++;
          end
        end
        default: ;                         // unused code: zeros, no change
      endcase
      predicted_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (predicted_q.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      want = predicted_q.pop_front();
      if (got.visible !== want.visible) begin
        $error("visible: expected %0d, got %0d", want.visible, got.visible);
        errors++;
      end
      if (got.frame !== want.frame) begin
        $error("frame: expected %0d, got %0d", want.frame, got.frame);
        errors++;
      end
      if (got.frame_updated !== want.frame_updated) begin
        $error("frame_updated: expected %0d, got %0d",
               want.frame_updated, got.frame_updated);
        errors++;
      end
      if (got.change_skipped !== want.change_skipped) begin
        $error("change_skipped: expected %0d, got %0d",
               want.change_skipped, got.change_skipped);
        errors++;
      end
    endfunction

    function int outstanding();
      return predicted_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and all inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [4:0]  in_slot = '0;
  logic [15:0] in_caster_size = '0;
  logic [15:0] in_depth_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_visible;
  logic [3:0]  out_frame;
  logic        out_frame_updated;
  logic        out_change_skipped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;   // chance per cycle that the sender holds off
  int          stall_pct = 0;       // chance per cycle that the receiver stalls

  shadow_frame_model frame_model = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_rescale_credit_throttle #(.SLOTS(N_SLOTS)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_slot            (in_slot),
    .in_caster_size     (in_caster_size),
    .in_depth_z         (in_depth_z),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_visible        (out_visible),
    .out_frame          (out_frame),
    .out_frame_updated  (out_frame_updated),
    .out_change_skipped (out_change_skipped),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Receiver back-pressure: redrawn every falling edge from the current mix.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor. Runs in the active region of the rising edge, so it sees the
  // values that the DUT registers on this same edge.
  always @(posedge clk) begin
    item_t req;
    res_t  got;
    cycle_count++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        frame_model.write_reg(reg_idx_t'(cfg_index), cfg_data);
      end
      if (in_valid && !in_stall) begin
        req = '{command: in_command, slot: in_slot,
                caster_size: in_caster_size, depth_z: in_depth_z};
        frame_model.note_request(req);
      end
      if (out_valid && !out_stall) begin
        got = '{visible: out_visible, frame: out_frame,
                frame_updated: out_frame_updated, change_skipped: out_change_skipped};
        frame_model.check_result(got);
      end
    end
  end

  // Watchdog: a hang or lost result ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, frame_model.outstanding());
    $display("tb_sprite_rescale_credit_throttle: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a falling edge.
  // --------------------------------------------------------------------------

  // One request: optional idle cycles, then hold it until accepted.
  task automatic send_request(input logic [1:0] cmd, input logic [4:0] slot,
                              input logic [15:0] size, input logic [15:0] depth);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_slot        <= slot;
    in_caster_size <= size;
    in_depth_z     <= depth;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (frame_model.outstanding() != 0);
  endtask

  // cfg_valid stays high across back-to-back writes; lowered by the caller.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers only change with the pipe empty.
  task automatic apply_settings(input logic [7:0] min_size, input logic [15:0] far,
                                input logic [7:0] budget, input logic [7:0] max_skip);
    drain();
    write_reg(REG_MIN_SIZE, 16'(min_size));
    write_reg(REG_FAR_CULL_DEPTH, far);
    write_reg(REG_RESCALE_BUDGET, 16'(budget));
    write_reg(REG_MAX_SKIP, 16'(max_skip));
    cfg_valid <= 1'b0;
  endtask

  // Random traffic, mostly place. Sizes cluster around the frame table (ties
  // and the 64/65 boundary included); depths cluster near zero and around the
  // far limit, with some full-range values.
  task automatic run_phase(input int count, input int place_pct, input int slot_hi);
    logic [1:0]  cmd;
    logic [4:0]  slot;
    logic [15:0] size;
    logic [15:0] depth;
    int          roll;
    int          near_far;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < place_pct) begin
        cmd = CMD_PLACE;
      end else begin
        roll = $urandom_range(9);
        if (roll < 4)      cmd = CMD_BEGIN_FRAME;
        else if (roll < 8) cmd = CMD_CLEAR_SLOT;
        else               cmd = CMD_UNUSED;
      end
      slot = 5'($urandom_range(slot_hi));
      roll = $urandom_range(99);
      if (roll < 55)      size = 16'($urandom_range(70));
      else if (roll < 80) size = 16'(FRAME_SIZES[$urandom_range(FRAME_COUNT - 1)]);
      else if (roll < 92) size = 16'($urandom_range(66, 60));
      else                size = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 50) begin
        depth = 16'($urandom_range(1023));
      end else if (roll < 60) begin
        near_far = int'(frame_model.regs.far_cull_depth) + int'($urandom_range(2)) - 1;
        if (near_far < 0) near_far = 0;
        if (near_far > 65535) near_far = 65535;
        depth = 16'(near_far);
      end else begin
        depth = 16'($urandom);
      end
      send_request(cmd, slot, size, depth);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // sender light, receiver heavy for the directed part and first phases
    send_idle_pct = 11;
    stall_pct     = 66;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset registers: min 4, far 65535, budget 2, max_skip 3.
    // No begin_frame yet, so credits are zero.
    send_request(CMD_PLACE, 5'd0, 16'd30, 16'd100);        // first place on empty slot
    send_request(CMD_PLACE, 5'd0, 16'd8, 16'd100);         // no credit: refused
    send_request(CMD_PLACE, 5'd0, 16'd8, 16'd100);
    send_request(CMD_PLACE, 5'd0, 16'd8, 16'd100);         // third refusal
    send_request(CMD_PLACE, 5'd0, 16'd8, 16'd100);         // skip limit forces it
    send_request(CMD_PLACE, 5'd0, 16'd8, 16'd100);         // same frame, skips clear
    send_request(CMD_BEGIN_FRAME, 5'd31, 16'hFFFF, 16'hFFFF);
    send_request(CMD_PLACE, 5'd0, 16'd64, 16'd0);          // largest size still searched in the table
    send_request(CMD_PLACE, 5'd0, 16'd65, 16'd0);          // past the table
    send_request(CMD_PLACE, 5'd0, 16'hFFFF, 16'd0);
    send_request(CMD_PLACE, 5'd1, 16'd3, 16'd0);           // below min size
    send_request(CMD_PLACE, 5'd1, 16'd4, 16'hFFFE);        // at min, just inside depth
    send_request(CMD_PLACE, 5'd1, 16'd4, 16'hFFFF);        // at far limit: hidden
    send_request(CMD_PLACE, 5'd31, 16'd13, 16'd5);         // tie between 11 and 15
    send_request(CMD_PLACE, 5'd31, 16'd20, 16'd5);         // tie, spends the last credit
    send_request(CMD_PLACE, 5'd31, 16'd27, 16'd5);         // out of credits: refused
    send_request(CMD_CLEAR_SLOT, 5'd31, 16'h0000, 16'h0000);
    send_request(CMD_PLACE, 5'd31, 16'd27, 16'd5);         // cleared slot changes free
    send_request(CMD_UNUSED, 5'd21, 16'hAAAA, 16'h5555);
    send_request(CMD_PLACE, 5'd2, 16'd0, 16'd0);           // zero size hidden
    send_request(CMD_CLEAR_SLOT, 5'd10, 16'hFFFF, 16'hFFFF); // slot never placed

    // No minimum, no budget, max_skip 0: every wanted change is forced.
    apply_settings(8'd0, 16'hFFFF, 8'd0, 8'd0);
    run_phase(200, 80, 31);

    // Moderate culling and budget on a few slots, so slots are revisited.
    apply_settings(8'd12, 16'd30000, 8'd4, 8'd3);
    run_phase(200, 85, 7);

    // Roles swap: bursty sender, mostly free receiver.
    send_idle_pct = 66;
    stall_pct     = 11;

    // Zero budget, highest skip limit, two slots: long refusal runs.
    apply_settings(8'd1, 16'hFFFF, 8'd0, 8'd255);
    run_phase(300, 97, 1);

    // Everything hidden: top minimum, far limit at zero, top budget.
    apply_settings(8'd255, 16'd0, 8'd255, 8'd255);
    run_phase(50, 80, 31);

    // Back to back, no idling at all.
    send_idle_pct = 0;
    stall_pct     = 0;

    apply_settings(8'd5, 16'd50000, 8'd1, 8'd1);
    run_phase(350, 80, 31);

    apply_settings(8'd4, 16'hFFFF, 8'd2, 8'd3);
    run_phase(150, 85, 15);

    // Let the pipe empty, then watch a little longer for stray results.
    drain();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("%0d requests in %0d cycles: %0d shadows shown, %0d culled",
             frame_model.requests, cycle_count, frame_model.shown, frame_model.culled);
    $display("frame changes applied %0d, refused %0d, results left over %0d",
             frame_model.changes, frame_model.refusals, frame_model.outstanding());
    if (frame_model.errors == 0 && frame_model.outstanding() == 0) begin
      $display("tb_sprite_rescale_credit_throttle: clean");
    end else begin
      $display("tb_sprite_rescale_credit_throttle: errors");
    end
    $finish;
  end

endmodule

[sprite_rescale_credit_throttle.f]
src/sprc_pkg.sv
src/sprc_cfg_regs.sv
src/sprc_core.sv
src/sprite_rescale_credit_throttle.sv
tb/sv/tb_sprite_rescale_credit_throttle.sv
